// File: design/u8u16_pkg.sv
package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_UNIT     = 2'd0,
    ST_BAD      = 2'd1,
    ST_OVERLONG = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] code_unit;
    status_t     status;
  } res_t;

  // Results caused by one byte: cnt is 0, 1 or 2, r0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } bundle_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

endpackage

// File: design/utf8_to_utf16_decoder.sv
// Throughput: one byte per cycle while the queue is not full; results go out one
// per cycle while pop is held; a surrogate pair or an error followed by a
// re-decoded byte takes two result transfers.
// A 4-entry result queue decouples the decoder from the output side.
// Reset (rst, synchronous) returns the decoder to idle and empties the queue.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic        last_of_run
);

  logic    accept;
  logic    wr;
  bundle_t bundle;

  assign accept = push && !full;

  u8u16_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .wr           (wr),
    .bundle       (bundle)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .bundle      (bundle),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .code_unit   (code_unit),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

// File: design/u8u16_front.sv
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       wr,
  output bundle_t    bundle
);

  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;
  localparam logic [1:0] ContTag  = 2'b10;

  localparam logic [20:0] Min2 = 21'h000080;
  localparam logic [20:0] Min3 = 21'h000800;
  localparam logic [20:0] Min4 = 21'h010000;
  localparam logic [20:0] SurLo = 21'h00D800;
  localparam logic [20:0] SurHi = 21'h00DFFF;
  localparam logic [20:0] MaxCp = 21'h10FFFF;
  localparam logic [15:0] HiSur = 16'hD800;
  localparam logic [15:0] LoSur = 16'hDC00;

  typedef struct packed {
    logic        has_res;
    res_t        res;
    logic [1:0]  rem;
    logic [1:0]  len;
    logic [20:0] acc;
  } lead_t;

  logic [1:0]  rem, rem_next;
  logic [1:0]  len, len_next;
  logic [20:0] acc, acc_next;

  lead_t       lead;
  logic [20:0] acc_cont;
  logic [1:0]  rem_dec;
  logic [20:0] sup;
  res_t        f0, f1;
  logic [1:0]  fcnt;

  function automatic res_t mk_res(input logic [15:0] u, input status_t s);
    res_t r;
    r.code_unit = u;
    r.status    = s;
    return r;
  endfunction

  function automatic lead_t decode_lead(input logic [7:0] b, input logic eoi);
    lead_t l;
    l.has_res = 1'b0;
    l.res     = mk_res(16'h0000, ST_UNIT);
    l.rem     = 2'd0;
    l.len     = 2'd0;
    l.acc     = '0;
    if (!b[7]) begin
      l.has_res = 1'b1;
      l.res     = mk_res({8'h00, b}, ST_UNIT);
    end else if (b[7:5] == Lead2Tag) begin
      l.len = 2'd1;
      l.acc = {16'h0000, b[4:0]};
    end else if (b[7:4] == Lead3Tag) begin
      l.len = 2'd2;
      l.acc = {17'h00000, b[3:0]};
    end else if (b[7:3] == Lead4Tag) begin
      l.len = 2'd3;
      l.acc = {18'h00000, b[2:0]};
    end else begin
      l.has_res = 1'b1;
      l.res     = mk_res(16'h0000, ST_BAD);
    end
    if (l.len != 2'd0) begin
      if (eoi) begin
        l.has_res = 1'b1;
        l.res     = mk_res(16'h0000, ST_TRUNC);
        l.len     = 2'd0;
        l.acc     = '0;
      end else begin
        l.rem = l.len;
      end
    end
    return l;
  endfunction

  assign lead     = decode_lead(in_byte, end_of_input);
  assign acc_cont = {acc[14:0], in_byte[5:0]};
  assign rem_dec  = rem - 2'd1;
  assign sup      = acc_cont - Min4;

  // Range checks on a completed code point; overlong takes priority.
  always_comb begin
    f0   = mk_res(16'h0000, ST_UNIT);
    f1   = mk_res(16'h0000, ST_UNIT);
    fcnt = 2'd1;
    case (len)
      2'd1: begin
        if (acc_cont < Min2) f0 = mk_res(16'h0000, ST_OVERLONG);
        else                 f0 = mk_res(acc_cont[15:0], ST_UNIT);
      end
      2'd2: begin
        if (acc_cont < Min3) begin
          f0 = mk_res(16'h0000, ST_OVERLONG);
        end else if (acc_cont >= SurLo && acc_cont <= SurHi) begin
          f0 = mk_res(16'h0000, ST_BAD);
        end else begin
          f0 = mk_res(acc_cont[15:0], ST_UNIT);
        end
      end
      default: begin
        if (acc_cont < Min4) begin
          f0 = mk_res(16'h0000, ST_OVERLONG);
        end else if (acc_cont > MaxCp) begin
          f0 = mk_res(16'h0000, ST_BAD);
        end else begin
          f0   = mk_res(HiSur | {6'd0, sup[19:10]}, ST_UNIT);
          f1   = mk_res(LoSur | {6'd0, sup[9:0]}, ST_UNIT);
          fcnt = 2'd2;
        end
      end
    endcase
  end

  always_comb begin
    rem_next   = rem;
    len_next   = len;
    acc_next   = acc;
    bundle.cnt = 2'd0;
    bundle.r0  = mk_res(16'h0000, ST_UNIT);
    bundle.r1  = mk_res(16'h0000, ST_UNIT);
    if (rem == 2'd0) begin
      rem_next   = lead.rem;
      len_next   = lead.len;
      acc_next   = lead.acc;
      bundle.cnt = {1'b0, lead.has_res};
      bundle.r0  = lead.res;
    end else if (in_byte[7:6] == ContTag) begin
      if (rem_dec == 2'd0) begin
        rem_next   = 2'd0;
        len_next   = 2'd0;
        acc_next   = '0;
        bundle.cnt = fcnt;
        bundle.r0  = f0;
        bundle.r1  = f1;
      end else if (end_of_input) begin
        rem_next   = 2'd0;
        len_next   = 2'd0;
        acc_next   = '0;
        bundle.cnt = 2'd1;
        bundle.r0  = mk_res(16'h0000, ST_TRUNC);
      end else begin
        rem_next = rem_dec;
        acc_next = acc_cont;
      end
    end else begin
      // Missing continuation: flag it, then take the byte as a new lead.
      rem_next   = lead.rem;
      len_next   = lead.len;
      acc_next   = lead.acc;
      bundle.r0  = mk_res(16'h0000, ST_BAD);
      bundle.r1  = lead.res;
      bundle.cnt = lead.has_res ? 2'd2 : 2'd1;
    end
  end

  assign wr = accept && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      len <= 2'd0;
      acc <= '0;
    end else if (accept) begin
      rem <= rem_next;
      len <= len_next;
      acc <= acc_next;
    end
  end

endmodule

// File: design/u8u16_back.sv
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  bundle_t     bundle,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic        last_of_run
);

  bundle_t          q [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QCntW-1:0] count;
  logic             sel;
  logic             rd_done;
  logic             take;
  bundle_t          head;
  res_t             cur;

  assign head  = q[rp];
  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign cur   = sel ? head.r1 : head.r0;

  assign code_unit   = cur.code_unit;
  assign status      = cur.status;
  assign last_of_run = sel || (head.cnt != 2'd2);

  assign take    = pop && !empty;
  // A bundle leaves after its last result is transferred.
  assign rd_done = take && (sel || (head.cnt != 2'd2));

  always_ff @(posedge clk) begin
    if (wr) q[wp] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
      sel   <= 1'b0;
    end else begin
      if (wr) wp <= wp + QPtrW'(1);
      if (rd_done) rp <= rp + QPtrW'(1);
      if (wr && !rd_done) count <= count + QCntW'(1);
      else if (!wr && rd_done) count <= count - QCntW'(1);
      if (take) sel <= !rd_done;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr || rd_done)
    else $error("write into full result queue");

  a_sel_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> !empty && head.cnt == 2'd2)
    else $error("second slot selected on a single-result entry");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !empty |-> head.cnt != 2'd0)
    else $error("queued entry carries no result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");
`endif

endmodule
